FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define SARM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SARM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/sarm_pkg.sv
// ---------------------------------------------------------------------------
// sarm_pkg
// Types and constants shared by the serial adapter register model.
// ---------------------------------------------------------------------------
package sarm_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_LINE  = 2'd2,
		CMD_TXRDY = 2'd3
	} cmd_t;

	localparam logic [1:0] DIV_MASTER_RESET = 2'b11;
	localparam logic [1:0] TXC_IRQ_EN       = 2'b01;
	localparam logic [7:0] VECTOR_RESET     = 8'd1;

	typedef struct packed {
		cmd_t        command;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [7:0]  line_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_active;
		logic       tx_valid;
		logic [7:0] tx_byte;
	} result_t;

endpackage

FILE: rtl/sarm_item_if.sv
// ---------------------------------------------------------------------------
// sarm_item_if
// Input channel: one bus access or line event per beat.
// ---------------------------------------------------------------------------
interface sarm_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic [7:0]  line_byte;

	modport source (output valid, command, address, write_data, line_byte, input ready);
	modport sink   (input valid, command, address, write_data, line_byte, output ready);
endinterface

FILE: rtl/sarm_result_if.sv
// ---------------------------------------------------------------------------
// sarm_result_if
// Output channel: one result beat per input beat.
// ---------------------------------------------------------------------------
interface sarm_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       irq_active;
	logic       tx_valid;
	logic [7:0] tx_byte;

	modport source (output valid, read_data, irq_active, tx_valid, tx_byte, input ready);
	modport sink   (input valid, read_data, irq_active, tx_valid, tx_byte, output ready);
endinterface

FILE: rtl/sarm_core.sv
// ---------------------------------------------------------------------------
// sarm_core
// Adapter register file and per-beat update: decode, flag update, IRQ.
// ---------------------------------------------------------------------------
module sarm_core import sarm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] base_address,
	input  logic        fire,
	input  item_t       item,
	output result_t     res
);

	logic [7:0] control_q, control_n;
	logic       rdrf_q, rdrf_n;
	logic       tdre_q, tdre_n;
	logic       ovrn_q, ovrn_n;
	logic [7:0] rx_byte_q, rx_byte_n;
	logic [7:0] tx_byte_q, tx_byte_n;
	logic [7:0] vector_q, vector_n;

	logic [15:0] data_addr;
	logic        is_ctrl;
	logic        is_data;
	logic        irq_cur;
	logic        irq_next;

	assign data_addr = base_address + 16'd1;
	assign is_ctrl   = (item.address == base_address);
	assign is_data   = !is_ctrl && (item.address == data_addr);

	assign irq_cur = (control_q[7] && (rdrf_q || ovrn_q)) ||
		((control_q[6:5] == TXC_IRQ_EN) && tdre_q);
	assign irq_next = (control_n[7] && (rdrf_n || ovrn_n)) ||
		((control_n[6:5] == TXC_IRQ_EN) && tdre_n);

	always_comb begin
		control_n     = control_q;
		rdrf_n        = rdrf_q;
		tdre_n        = tdre_q;
		ovrn_n        = ovrn_q;
		rx_byte_n     = rx_byte_q;
		tx_byte_n     = tx_byte_q;
		vector_n      = vector_q;
		res.read_data = 8'd0;
		res.tx_valid  = 1'b0;
		res.tx_byte   = 8'd0;
		unique case (item.command)
			CMD_READ: begin
				if (is_ctrl) begin
					res.read_data = {irq_cur, 1'b0, ovrn_q, 3'b000, tdre_q, rdrf_q};
				end else if (is_data) begin
					rdrf_n        = 1'b0;
					ovrn_n        = 1'b0;
					res.read_data = rx_byte_q;
				end else begin
					res.read_data = vector_q;
				end
			end
			CMD_WRITE: begin
				if (is_ctrl) begin
					control_n = item.write_data;
					if (item.write_data[1:0] == DIV_MASTER_RESET) begin
						rdrf_n = 1'b0;
						ovrn_n = 1'b0;
						tdre_n = 1'b1;
					end
				end else if (is_data) begin
					tx_byte_n = item.write_data;
					tdre_n    = 1'b0;
				end else begin
					vector_n = item.write_data;
				end
			end
			CMD_LINE: begin
				rx_byte_n = item.line_byte;
				if (rdrf_q) begin
					ovrn_n = 1'b1;
				end
				rdrf_n = 1'b1;
			end
			CMD_TXRDY: begin
				if (!tdre_q) begin
					res.tx_valid = 1'b1;
					res.tx_byte  = tx_byte_q;
					tdre_n       = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.irq_active = irq_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= 8'd0;
			rdrf_q    <= 1'b0;
			tdre_q    <= 1'b1;
			ovrn_q    <= 1'b0;
			rx_byte_q <= 8'd0;
			tx_byte_q <= 8'd0;
			vector_q  <= VECTOR_RESET;
		end else if (fire) begin
			control_q <= control_n;
			rdrf_q    <= rdrf_n;
			tdre_q    <= tdre_n;
			ovrn_q    <= ovrn_n;
			rx_byte_q <= rx_byte_n;
			tx_byte_q <= tx_byte_n;
			vector_q  <= vector_n;
		end
	end

endmodule

FILE: rtl/serial_adapter_register_model_unit.sv
// ---------------------------------------------------------------------------
// serial_adapter_register_model_unit
// Register model of a serial adapter behind valid/ready channels.
// ---------------------------------------------------------------------------
// Each input beat (bus read, bus write, received line byte or transmit line
// ready) gives exactly one result beat. Beats are taken one per clock unless
// results stall, and pass an input register, then the adapter register
// update and a result register. The result register parts the channels: a
// beat is taken while a result waits if the input register is free. The user
// writes base_address via cfg_we/cfg_data only while no beat is in flight;
// the block does not check it. Data register: base_address + 1, 16-bit wrap.
module serial_adapter_register_model_unit import sarm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	sarm_item_if.sink     item_ch,
	sarm_result_if.source result_ch
);

	`include "assert_macros.svh"

	logic [15:0] base_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res;
	logic        s2_free;
	logic        fire;
	logic        take;

	assign s2_free       = !valid_s2 || result_ch.ready;
	assign fire          = valid_s1 && s2_free;
	assign item_ch.ready = !valid_s1 || s2_free;
	assign take          = item_ch.valid && item_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 16'd0;
		end else if (cfg_we) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.command    <= cmd_t'(item_ch.command);
			item_s1.address    <= item_ch.address;
			item_s1.write_data <= item_ch.write_data;
			item_s1.line_byte  <= item_ch.line_byte;
		end
	end

	sarm_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_address (base_q),
		.fire         (fire),
		.item         (item_s1),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (result_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign result_ch.valid      = valid_s2;
	assign result_ch.read_data  = res_s2.read_data;
	assign result_ch.irq_active = res_s2.irq_active;
	assign result_ch.tx_valid   = res_s2.tx_valid;
	assign result_ch.tx_byte    = res_s2.tx_byte;

	// a line hand-off never comes with read data
	`SARM_ASSERT_IMPL(a_tx_no_rdata, valid_s2 && res_s2.tx_valid, res_s2.read_data == 8'd0, "tx beat carries read data")
	`SARM_ASSERT_IMPL(a_tx_byte_zero, valid_s2 && !res_s2.tx_valid, res_s2.tx_byte == 8'd0, "tx byte without tx_valid")
	// full pipe with a stalled result holds off input
	`SARM_ASSERT_IMPL(a_stall_blocks, valid_s1 && valid_s2 && !result_ch.ready, !item_ch.ready, "input taken while pipe full")
	`SARM_ASSERT(a_fire_ready, !fire || s2_free, "update while result stage blocked")

endmodule
